FILE: design/source_token_lexer_assert.svh
// Assertion macros shared by the lexer modules.
`ifndef SOURCE_TOKEN_LEXER_ASSERT_SVH
`define SOURCE_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");

// Next-cycle implication, checked outside reset.
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

FILE: design/stl_pkg.sv
// Shared types, token codes and keyword table for the source token lexer.
package stl_pkg;

   localparam int TEXT_MAX_LENGTH = 63;
   localparam int LINE_WIDTH      = 20;
   localparam int CNT_W           = $clog2(TEXT_MAX_LENGTH + 1);
   localparam int COL_W           = 16;
   localparam int ERR_W           = 16;
   localparam int KW_COUNT        = 15;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [5:0] K_EOF      = 6'd0;
   localparam logic [5:0] K_UNKNOWN  = 6'd1;
   localparam logic [5:0] K_INT      = 6'd2;
   localparam logic [5:0] K_CHAR     = 6'd3;
   localparam logic [5:0] K_IDENT    = 6'd4;
   localparam logic [5:0] K_KW0      = 6'd5;
   localparam logic [5:0] K_COMMA    = 6'd20;
   localparam logic [5:0] K_SEMI     = 6'd21;
   localparam logic [5:0] K_EQ       = 6'd22;
   localparam logic [5:0] K_EQEQ     = 6'd23;
   localparam logic [5:0] K_EXCLA    = 6'd24;
   localparam logic [5:0] K_EXCLAEQ  = 6'd25;
   localparam logic [5:0] K_AMP      = 6'd26;
   localparam logic [5:0] K_BAR      = 6'd27;
   localparam logic [5:0] K_PLUS     = 6'd28;
   localparam logic [5:0] K_MINUS    = 6'd29;
   localparam logic [5:0] K_STAR     = 6'd30;
   localparam logic [5:0] K_SLASH    = 6'd31;
   localparam logic [5:0] K_PERCENT  = 6'd32;
   localparam logic [5:0] K_LT       = 6'd33;
   localparam logic [5:0] K_LE       = 6'd34;
   localparam logic [5:0] K_GT       = 6'd35;
   localparam logic [5:0] K_GE       = 6'd36;
   localparam logic [5:0] K_LPAREN   = 6'd37;
   localparam logic [5:0] K_RPAREN   = 6'd38;
   localparam logic [5:0] K_LBRACE   = 6'd39;
   localparam logic [5:0] K_RBRACE   = 6'd40;
   localparam logic [5:0] K_LBRACKET = 6'd41;
   localparam logic [5:0] K_RBRACKET = 6'd42;

   // keyword spellings, right-justified
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "if", "else", "while", "loop", "break", "continue", "puti", "putc",
      "geti", "getc", "array", "halt", "func", "return", "const"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd6, 4'd5
   };

   typedef struct packed {
      logic [5:0]            kind;
      logic signed [31:0]    value;
      logic [5:0]            length;
      logic                  overflow;
      logic [LINE_WIDTH-1:0] line;
      logic [COL_W-1:0]      column;
      logic [ERR_W-1:0]      errors;
      logic                  last;
   } token_type;

   // up to two tokens produced by one beat, in order
   typedef struct packed {
      logic      v0;
      logic      v1;
      token_type t0;
      token_type t1;
   } push_type;

   // character at position pos of keyword k, zero past its end
   function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned pos);
      logic [63:0] t;
      int unsigned l;
      t = KW_TEXT[k];
      l = KW_LEN[k];
      if (pos < l) return t[8*(l-1-pos) +: 8];
      return 8'h00;
   endfunction

endpackage

FILE: design/stl_if.sv
// Request and response channel interfaces of the lexer.
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;
   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface stl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [5:0]                    token_kind;
   logic signed [31:0]            token_value;
   logic [5:0]                    token_length;
   logic                          text_overflow;
   logic [stl_pkg::LINE_WIDTH-1:0] start_line;
   logic [stl_pkg::COL_W-1:0]     start_column;
   logic [stl_pkg::ERR_W-1:0]     errors_so_far;
   logic                          last_of_run;
   modport source (output valid, token_kind, token_value, token_length, text_overflow,
                   start_line, start_column, errors_so_far, last_of_run, input ready);
   modport sink (input valid, token_kind, token_value, token_length, text_overflow,
                 start_line, start_column, errors_so_far, last_of_run, output ready);
endinterface

FILE: design/source_token_lexer.sv
// Top level of the streaming source token lexer.
//
//   channel | dir | beat contents                                  | handshake
//   req     | in  | data_byte, end_of_input                        | valid/ready
//   rsp     | out | kind, value, length, overflow, line, column,   | valid/ready
//           |     | errors so far, last_of_run                     |
//
// One request beat per cycle while req.ready is high; each beat makes zero, one or two tokens.
// Tokens are registered into a 4-entry queue, whose head drives rsp.
// A beat that makes two tokens takes two places in the queue, so a run of such
// beats is held back by the queue drain port, which sets the beat rate there.
// req.ready is high while the queue has room for two tokens; rsp stalls back
// up into req only through that check.
// Synchronous active-high reset: idle, line 1 column 1, error count zero.
module source_token_lexer (
   input  logic        clock,
   input  logic        reset,
   stl_req_if.sink     req_chan,
   stl_rsp_if.source   rsp_chan
);

   stl_pkg::push_type  push;
   stl_pkg::token_type head;
   logic               room;
   logic               accept;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   // per-beat lexing: mode, text accumulators, position counters
   stl_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_chan.data_byte),
      .end_of_input (req_chan.end_of_input),
      .push         (push)
   );

   // token queue toward rsp
   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_token (head)
   );

   assign rsp_chan.token_kind    = head.kind;
   assign rsp_chan.token_value   = head.value;
   assign rsp_chan.token_length  = head.length;
   assign rsp_chan.text_overflow = head.overflow;
   assign rsp_chan.start_line    = head.line;
   assign rsp_chan.start_column  = head.column;
   assign rsp_chan.errors_so_far = head.errors;
   assign rsp_chan.last_of_run   = head.last;

endmodule

FILE: design/stl_core.sv
// Lexer state registers and per-beat next-state and token logic.
`include "source_token_lexer_assert.svh"

module stl_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_input,
   output stl_pkg::push_type  push
);

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_INT, M_IDENT, M_CH_OPEN, M_CH_ESC, M_CH_HEX,
      M_CH_CLOSE, M_OP_EQ, M_OP_EX, M_OP_LT, M_OP_GT
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic [31:0]                       acc_ff, acc_in;
   logic [stl_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [stl_pkg::KW_COUNT-1:0]      mask_ff, mask_in;
   logic                              ovf_ff, ovf_in;
   logic [1:0]                        hexn_ff, hexn_in;
   logic [stl_pkg::LINE_WIDTH-1:0]    line_ff, line_in, sline_ff, sline_in;
   logic [stl_pkg::COL_W-1:0]         col_ff, col_in, scol_ff, scol_in;
   logic [stl_pkg::ERR_W-1:0]         err_ff, err_in;

   logic                              is_digit, is_alpha, is_part, is_space, is_print;
   logic                              hex_ok;
   logic [3:0]                        hex_v;
   logic [7:0]                        esc_v;
   logic                              room;
   logic [31:0]                       acc_app;
   logic [stl_pkg::CNT_W-1:0]         cnt_app;
   logic [stl_pkg::KW_COUNT-1:0]      mask_app, mask_first;
   logic [5:0]                        ident_kind, single_kind;
   logic                              a_v, b_v, go_idle;
   stl_pkg::token_type                ta, tb;

   // character classes
   always_comb begin
      is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
      is_alpha = ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) ||
                 ((data_byte >= 8'h41) && (data_byte <= 8'h5A));
      is_part  = is_digit || is_alpha || (data_byte == 8'h5F);
      is_space = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
      is_print = (data_byte >= 8'h20) && (data_byte <= 8'h7E);
      hex_ok   = 1'b1;
      hex_v    = data_byte[3:0];
      if (is_digit) hex_v = data_byte[3:0];
      else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
               (data_byte >= 8'h41 && data_byte <= 8'h46)) hex_v = 4'(data_byte[2:0] + 3'd1) + 4'd8;
      else hex_ok = 1'b0;
      case (data_byte)
         8'h61:   esc_v = 8'h07;
         8'h62:   esc_v = 8'h08;
         8'h65:   esc_v = 8'h1B;
         8'h72:   esc_v = 8'h0D;
         8'h6E:   esc_v = 8'h0A;
         8'h74:   esc_v = 8'h09;
         default: esc_v = data_byte;
      endcase
   end

   // text append and keyword filter
   always_comb begin
      room    = int'(cnt_ff) < stl_pkg::TEXT_MAX_LENGTH;
      acc_app = room ? (acc_ff << 3) + (acc_ff << 1) + 32'(data_byte - 8'h30) : acc_ff;
      cnt_app = room ? cnt_ff + 1'b1 : cnt_ff;
      for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
         mask_app[k]   = room ? (mask_ff[k] && (cnt_ff < stl_pkg::KW_LEN[k]) &&
                         (stl_pkg::kw_char(k, int'(cnt_ff)) == data_byte)) : mask_ff[k];
         mask_first[k] = stl_pkg::kw_char(k, 0) == data_byte;
      end
      ident_kind = stl_pkg::K_IDENT;
      for (int k = stl_pkg::KW_COUNT - 1; k >= 0; k--)
         if (!ovf_ff && mask_ff[k] && (cnt_ff == stl_pkg::KW_LEN[k]))
            ident_kind = 6'(int'(stl_pkg::K_KW0) + k);
      case (mode_ff)
         M_OP_EQ: single_kind = stl_pkg::K_EQ;
         M_OP_EX: single_kind = stl_pkg::K_EXCLA;
         M_OP_LT: single_kind = stl_pkg::K_LT;
         default: single_kind = stl_pkg::K_GT;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      mask_in  = mask_ff;
      ovf_in   = ovf_ff;
      hexn_in  = hexn_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      err_in   = err_ff;
      a_v      = 1'b0;
      b_v      = 1'b0;
      go_idle  = 1'b0;
      ta       = '0;
      tb       = '0;
      if (end_of_input) begin
         case (mode_ff)
            M_INT: begin
               a_v = 1'b1; ta.kind = stl_pkg::K_INT; ta.value = acc_ff;
               ta.length = 6'(cnt_ff); ta.overflow = ovf_ff;
            end
            M_IDENT: begin
               a_v = 1'b1; ta.kind = ident_kind;
               ta.length = 6'(cnt_ff); ta.overflow = ovf_ff;
            end
            M_OP_EQ, M_OP_EX, M_OP_LT, M_OP_GT: begin
               a_v = 1'b1; ta.kind = single_kind;
            end
            M_CH_OPEN, M_CH_ESC: begin
               a_v = 1'b1; ta.kind = stl_pkg::K_CHAR;
            end
            M_CH_HEX, M_CH_CLOSE: begin
               a_v = 1'b1; ta.kind = stl_pkg::K_CHAR; ta.value = acc_ff;
            end
            default: ;
         endcase
         mode_in  = M_IDLE;
         sline_in = line_ff;
         scol_in  = col_ff;
         b_v      = 1'b1;
         tb.kind  = stl_pkg::K_EOF;
      end else begin
         case (mode_ff)
            M_COMMENT: if (data_byte == 8'h0A) mode_in = M_IDLE;
            M_INT: begin
               if (is_digit) begin
                  acc_in = acc_app; cnt_in = cnt_app; ovf_in = ovf_ff || !room;
               end else begin
                  a_v = 1'b1; ta.kind = stl_pkg::K_INT; ta.value = acc_ff;
                  ta.length = 6'(cnt_ff); ta.overflow = ovf_ff; go_idle = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_part) begin
                  mask_in = mask_app; cnt_in = cnt_app; ovf_in = ovf_ff || !room;
               end else begin
                  a_v = 1'b1; ta.kind = ident_kind; ta.length = 6'(cnt_ff);
                  ta.overflow = ovf_ff; go_idle = 1'b1;
               end
            end
            M_OP_EQ, M_OP_EX, M_OP_LT, M_OP_GT: begin
               a_v = 1'b1;
               mode_in = M_IDLE;
               if (data_byte == 8'h3D) ta.kind = single_kind + 6'd1;
               else begin
                  ta.kind = single_kind; go_idle = 1'b1;
               end
            end
            M_CH_OPEN: begin
               if (data_byte == 8'h5C) mode_in = M_CH_ESC;
               else if (is_print) begin
                  acc_in = 32'(data_byte); mode_in = M_CH_CLOSE;
               end else begin
                  a_v = 1'b1; ta.kind = stl_pkg::K_CHAR; go_idle = 1'b1;
               end
            end
            M_CH_ESC: begin
               if (data_byte == 8'h78) begin
                  acc_in = 32'h78; hexn_in = 2'd0; mode_in = M_CH_HEX;
               end else begin
                  acc_in = 32'(esc_v); mode_in = M_CH_CLOSE;
               end
            end
            M_CH_HEX: begin
               if (hex_ok) begin
                  if (hexn_ff == 2'd0) begin
                     acc_in = 32'(hex_v); hexn_in = 2'd1;
                  end else begin
                     acc_in = 32'({acc_ff[3:0], hex_v}); hexn_in = 2'd2;
                     mode_in = M_CH_CLOSE;
                  end
               end else begin
                  a_v = 1'b1; ta.kind = stl_pkg::K_CHAR; ta.value = acc_ff;
                  mode_in = M_IDLE;
                  go_idle = data_byte != 8'h27;
               end
            end
            M_CH_CLOSE: begin
               a_v = 1'b1; ta.kind = stl_pkg::K_CHAR; ta.value = acc_ff;
               mode_in = M_IDLE;
               go_idle = data_byte != 8'h27;
            end
            default: go_idle = 1'b1;
         endcase

         // byte lexed from the idle state
         if (go_idle) begin
            mode_in = M_IDLE;
            if (!is_space && data_byte != 8'h23) begin
               sline_in = line_ff;
               scol_in  = col_ff;
            end
            if (is_space) begin
            end else if (data_byte == 8'h23) begin
               mode_in = M_COMMENT;
            end else if (data_byte == 8'h27) begin
               acc_in = '0; mode_in = M_CH_OPEN;
            end else if (is_digit) begin
               acc_in = 32'(data_byte - 8'h30); cnt_in = stl_pkg::CNT_W'(1);
               ovf_in = 1'b0; mask_in = '1; mode_in = M_INT;
            end else if (is_part) begin
               acc_in = '0; cnt_in = stl_pkg::CNT_W'(1);
               ovf_in = 1'b0; mask_in = mask_first; mode_in = M_IDENT;
            end else begin
               b_v = 1'b1;
               case (data_byte)
                  8'h2C: tb.kind = stl_pkg::K_COMMA;
                  8'h3B: tb.kind = stl_pkg::K_SEMI;
                  8'h26: tb.kind = stl_pkg::K_AMP;
                  8'h7C: tb.kind = stl_pkg::K_BAR;
                  8'h2B: tb.kind = stl_pkg::K_PLUS;
                  8'h2D: tb.kind = stl_pkg::K_MINUS;
                  8'h2A: tb.kind = stl_pkg::K_STAR;
                  8'h2F: tb.kind = stl_pkg::K_SLASH;
                  8'h25: tb.kind = stl_pkg::K_PERCENT;
                  8'h28: tb.kind = stl_pkg::K_LPAREN;
                  8'h29: tb.kind = stl_pkg::K_RPAREN;
                  8'h7B: tb.kind = stl_pkg::K_LBRACE;
                  8'h7D: tb.kind = stl_pkg::K_RBRACE;
                  8'h5B: tb.kind = stl_pkg::K_LBRACKET;
                  8'h5D: tb.kind = stl_pkg::K_RBRACKET;
                  8'h3D: begin b_v = 1'b0; mode_in = M_OP_EQ; end
                  8'h21: begin b_v = 1'b0; mode_in = M_OP_EX; end
                  8'h3C: begin b_v = 1'b0; mode_in = M_OP_LT; end
                  8'h3E: begin b_v = 1'b0; mode_in = M_OP_GT; end
                  default: begin
                     tb.kind = stl_pkg::K_UNKNOWN;
                     if (err_ff != '1) err_in = err_ff + 1'b1;
                  end
               endcase
            end
         end

         // position advance
         if (data_byte == 8'h0A) begin
            if (line_ff != '1) line_in = line_ff + 1'b1;
            col_in = stl_pkg::COL_W'(1);
         end else if (col_ff != '1) begin
            col_in = col_ff + 1'b1;
         end
      end

      ta.line   = sline_ff;
      ta.column = scol_ff;
      ta.errors = err_ff;
      ta.last   = !b_v;
      tb.line   = sline_in;
      tb.column = scol_in;
      tb.errors = err_in;
      tb.last   = 1'b1;
      push.v0   = accept && a_v;
      push.v1   = accept && b_v;
      push.t0   = ta;
      push.t1   = tb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         mask_ff  <= '1;
         ovf_ff   <= 1'b0;
         hexn_ff  <= '0;
         line_ff  <= stl_pkg::LINE_WIDTH'(1);
         col_ff   <= stl_pkg::COL_W'(1);
         sline_ff <= stl_pkg::LINE_WIDTH'(1);
         scol_ff  <= stl_pkg::COL_W'(1);
         err_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         mask_ff  <= mask_in;
         ovf_ff   <= ovf_in;
         hexn_ff  <= hexn_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         err_ff   <= err_in;
      end
   end

   `STL_ASSERT_NEXT(a_eof_idle, clock, reset, accept && end_of_input, mode_ff == M_IDLE)
   `STL_ASSERT_NOW(a_err_step, clock, reset, accept, (err_in == err_ff) || (err_in == err_ff + 1'b1))
   `STL_ASSERT_NOW(a_text_bound, clock, reset, 1'b1, int'(cnt_ff) <= stl_pkg::TEXT_MAX_LENGTH)

endmodule

FILE: design/stl_queue.sv
// Result queue: takes up to two tokens a beat, delivers one a cycle while out_ready is high.
`include "source_token_lexer_assert.svh"

module stl_queue (
   input  logic               clock,
   input  logic               reset,
   input  stl_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output stl_pkg::token_type out_token
);

   stl_pkg::token_type              mem_ff [stl_pkg::QUEUE_DEPTH];
   logic [stl_pkg::QPTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [stl_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            pop;
   logic [1:0]                      n_push;
   stl_pkg::token_type              first;

   always_comb begin
      room      = cnt_ff <= stl_pkg::QCNT_W'(stl_pkg::QUEUE_DEPTH - 2);
      out_valid = cnt_ff != '0;
      out_token = mem_ff[rd_ff];
      pop       = out_valid && out_ready;
      n_push    = 2'(push.v0) + 2'(push.v1);
      first     = push.v0 ? push.t0 : push.t1;
      wr_in     = wr_ff + stl_pkg::QPTR_W'(n_push);
      rd_in     = rd_ff + stl_pkg::QPTR_W'(pop);
      cnt_in    = cnt_ff + stl_pkg::QCNT_W'(n_push) - stl_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ff] <= first;
      if (n_push == 2'd2) mem_ff[wr_ff + 1'b1] <= push.t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `STL_ASSERT_NOW(a_no_overrun, clock, reset, n_push != 2'd0, cnt_ff <= stl_pkg::QCNT_W'(stl_pkg::QUEUE_DEPTH) - stl_pkg::QCNT_W'(n_push))
   `STL_ASSERT_NOW(a_ptr_track, clock, reset, 1'b1, stl_pkg::QPTR_W'(wr_ff - rd_ff) == stl_pkg::QPTR_W'(cnt_ff))
   `STL_ASSERT_NEXT(a_drain, clock, reset, cnt_ff == 1 && pop && n_push == 2'd0, !out_valid)

endmodule

FILE: tb/tb_source_token_lexer.sv
// Self-checking testbench for the source token lexer: byte streams in, tokens checked.
module tb_source_token_lexer;

   // lexer modes tracked by the predictor
   typedef enum logic [3:0] {
      LM_IDLE, LM_COMMENT, LM_INT, LM_IDENT, LM_CH_OPEN, LM_CH_ESC, LM_CH_HEX,
      LM_CH_CLOSE, LM_OP_EQ, LM_OP_EX, LM_OP_LT, LM_OP_GT
   } lex_mode_e;

   localparam logic [7:0] ESC_CODE = 8'h1B;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 490;

   // Token predictor and checker. note_beat runs one accepted beat through
   // the lexer rules and queues the tokens it makes; check_token compares
   // a response beat with the oldest queued token.
   class lexer_token_checker;
      stl_pkg::token_type expected_tokens[$];
      int        fails;
      lex_mode_e mode;
      logic [31:0] acc;
      int        cnt;
      logic [stl_pkg::KW_COUNT-1:0] kw_mask;
      logic      ovf;
      int        hex_cnt;
      logic [stl_pkg::LINE_WIDTH-1:0] line, tok_line;
      logic [stl_pkg::COL_W-1:0] col, tok_col;
      logic [stl_pkg::ERR_W-1:0] errs;
      stl_pkg::token_type step_toks[$];

      function new();
         fails = 0;
         mode = LM_IDLE; acc = 0; cnt = 0; kw_mask = '1; ovf = 0; hex_cnt = 0;
         line = 1; col = 1; tok_line = 1; tok_col = 1; errs = 0;
      endfunction

      function string kw_word(int k);
         case (k)
            0: return "if";     1: return "else";  2: return "while";
            3: return "loop";   4: return "break"; 5: return "continue";
            6: return "puti";   7: return "putc";  8: return "geti";
            9: return "getc";   10: return "array"; 11: return "halt";
            12: return "func";  13: return "return";
            default: return "const";
         endcase
      endfunction

      function bit is_digit(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction
      function bit is_part(logic [7:0] c);
         return c == "_" || is_alpha(c) || is_digit(c);
      endfunction

      function int hex_val(logic [7:0] c);
         if (is_digit(c)) return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function logic [7:0] esc_value(logic [7:0] c);
         case (c)
            "a": return 8'd7;
            "b": return 8'd8;
            "e": return ESC_CODE;
            "r": return 8'd13;
            "n": return 8'd10;
            "t": return 8'd9;
            default: return c;
         endcase
      endfunction

      function void emit(logic [5:0] kind, logic [31:0] value, int len, logic of);
         stl_pkg::token_type t;
         t.kind = kind; t.value = value; t.length = len[5:0]; t.overflow = of;
         t.line = tok_line; t.column = tok_col; t.errors = errs; t.last = 0;
         step_toks.push_back(t);
      endfunction

      function void emit_ident();
         logic [5:0] kind;
         kind = stl_pkg::K_IDENT;
         // overflowed text never matches a keyword
         if (!ovf)
            for (int k = 0; k < stl_pkg::KW_COUNT; k++)
               if (kw_mask[k] && kw_word(k).len() == cnt) begin
                  kind = 6'(int'(stl_pkg::K_KW0) + k);
                  break;
               end
         emit(kind, 0, cnt, ovf);
      endfunction

      function void begin_text();
         acc = 0; cnt = 0; ovf = 0; kw_mask = '1;
      endfunction

      function void add_char(logic [7:0] c, bit ident);
         string w;
         if (cnt >= stl_pkg::TEXT_MAX_LENGTH) begin
            ovf = 1;
            return;
         end
         if (ident) begin
            for (int k = 0; k < stl_pkg::KW_COUNT; k++) begin
               w = kw_word(k);
               if (cnt >= w.len() || w[cnt] != c) kw_mask[k] = 0;
            end
         end else
            acc = acc * 10 + 32'(c - 8'h30);
         cnt++;
      endfunction

      function logic [5:0] op_single(lex_mode_e m);
         case (m)
            LM_OP_EQ: return stl_pkg::K_EQ;
            LM_OP_EX: return stl_pkg::K_EXCLA;
            LM_OP_LT: return stl_pkg::K_LT;
            default:  return stl_pkg::K_GT;
         endcase
      endfunction

      // one pass over byte c; 1 when c is consumed
      function bit lex_byte(logic [7:0] c);
         int h;
         logic [5:0] single;
         case (mode)
            LM_COMMENT: begin
               if (c == 8'h0A) mode = LM_IDLE;
               return 1;
            end
            LM_INT: begin
               if (is_digit(c)) begin add_char(c, 0); return 1; end
               emit(stl_pkg::K_INT, acc, cnt, ovf);
               mode = LM_IDLE;
               return 0;
            end
            LM_IDENT: begin
               if (is_part(c)) begin add_char(c, 1); return 1; end
               emit_ident();
               mode = LM_IDLE;
               return 0;
            end
            LM_OP_EQ, LM_OP_EX, LM_OP_LT, LM_OP_GT: begin
               single = op_single(mode);
               mode = LM_IDLE;
               if (c == "=") begin emit(single + 6'd1, 0, 0, 0); return 1; end
               emit(single, 0, 0, 0);
               return 0;
            end
            LM_CH_OPEN: begin
               if (c == "\\") begin mode = LM_CH_ESC; return 1; end
               if (c >= 8'h20 && c <= 8'h7E) begin
                  acc = 32'(c); mode = LM_CH_CLOSE; return 1;
               end
               // non-printable right after the quote: value 0, byte lexed again
               emit(stl_pkg::K_CHAR, 0, 0, 0);
               mode = LM_IDLE;
               return 0;
            end
            LM_CH_ESC: begin
               if (c == "x") begin
                  acc = 32'h78; hex_cnt = 0; mode = LM_CH_HEX;
               end else begin
                  acc = 32'(esc_value(c)); mode = LM_CH_CLOSE;
               end
               return 1;
            end
            LM_CH_HEX: begin
               h = hex_val(c);
               if (h >= 0) begin
                  if (hex_cnt == 0) begin
                     acc = 32'(h); hex_cnt = 1;
                  end else begin
                     acc = ((acc & 32'hF) << 4) | 32'(h); hex_cnt = 2; mode = LM_CH_CLOSE;
                  end
                  return 1;
               end
               mode = LM_CH_CLOSE;
               return 0;
            end
            LM_CH_CLOSE: begin
               emit(stl_pkg::K_CHAR, acc, 0, 0);
               mode = LM_IDLE;
               return c == "'";
            end
            default: ;
         endcase
         mode = LM_IDLE;
         if (c == " " || (c >= 8'd9 && c <= 8'd13)) return 1;
         if (c == "#") begin mode = LM_COMMENT; return 1; end
         tok_line = line; tok_col = col;
         if (c == "'") begin acc = 0; mode = LM_CH_OPEN; return 1; end
         if (is_digit(c)) begin begin_text(); add_char(c, 0); mode = LM_INT; return 1; end
         if (c == "_" || is_alpha(c)) begin
            begin_text(); add_char(c, 1); mode = LM_IDENT; return 1;
         end
         case (c)
            ",": begin emit(stl_pkg::K_COMMA, 0, 0, 0); return 1; end
            ";": begin emit(stl_pkg::K_SEMI, 0, 0, 0); return 1; end
            "&": begin emit(stl_pkg::K_AMP, 0, 0, 0); return 1; end
            "|": begin emit(stl_pkg::K_BAR, 0, 0, 0); return 1; end
            "+": begin emit(stl_pkg::K_PLUS, 0, 0, 0); return 1; end
            "-": begin emit(stl_pkg::K_MINUS, 0, 0, 0); return 1; end
            "*": begin emit(stl_pkg::K_STAR, 0, 0, 0); return 1; end
            "/": begin emit(stl_pkg::K_SLASH, 0, 0, 0); return 1; end
            "%": begin emit(stl_pkg::K_PERCENT, 0, 0, 0); return 1; end
            "(": begin emit(stl_pkg::K_LPAREN, 0, 0, 0); return 1; end
            ")": begin emit(stl_pkg::K_RPAREN, 0, 0, 0); return 1; end
            "{": begin emit(stl_pkg::K_LBRACE, 0, 0, 0); return 1; end
            "}": begin emit(stl_pkg::K_RBRACE, 0, 0, 0); return 1; end
            "[": begin emit(stl_pkg::K_LBRACKET, 0, 0, 0); return 1; end
            "]": begin emit(stl_pkg::K_RBRACKET, 0, 0, 0); return 1; end
            "=": begin mode = LM_OP_EQ; return 1; end
            "!": begin mode = LM_OP_EX; return 1; end
            "<": begin mode = LM_OP_LT; return 1; end
            ">": begin mode = LM_OP_GT; return 1; end
            default: ;
         endcase
         if (errs != '1) errs++;
         emit(stl_pkg::K_UNKNOWN, 0, 0, 0);
         return 1;
      endfunction

      function void note_beat(logic [7:0] b, logic eoi);
         step_toks.delete();
         if (eoi) begin
            case (mode)
               LM_INT:   emit(stl_pkg::K_INT, acc, cnt, ovf);
               LM_IDENT: emit_ident();
               LM_OP_EQ, LM_OP_EX, LM_OP_LT, LM_OP_GT: emit(op_single(mode), 0, 0, 0);
               LM_CH_OPEN, LM_CH_ESC: emit(stl_pkg::K_CHAR, 0, 0, 0);
               LM_CH_HEX, LM_CH_CLOSE: emit(stl_pkg::K_CHAR, acc, 0, 0);
               default: ;
            endcase
            mode = LM_IDLE;
            tok_line = line; tok_col = col;
            emit(stl_pkg::K_EOF, 0, 0, 0);
         end else begin
            for (int g = 0; g < 4; g++)
               if (lex_byte(b)) break;
            if (b == 8'h0A) begin
               if (line != '1) line++;
               col = 1;
            end else if (col != '1)
               col++;
         end
         if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1;
         foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
      endfunction

      function void mismatch(string field, longint exp_v, longint got_v);
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, got_v);
         fails++;
      endfunction

      function void check_token(stl_pkg::token_type got);
         stl_pkg::token_type exp_t;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none actual kind %0d",
                     $time, got.kind);
            fails++;
            return;
         end
         exp_t = expected_tokens.pop_front();
         if (got.kind !== exp_t.kind)         mismatch("kind", exp_t.kind, got.kind);
         if (got.value !== exp_t.value)       mismatch("value", exp_t.value, got.value);
         if (got.length !== exp_t.length)     mismatch("length", exp_t.length, got.length);
         if (got.overflow !== exp_t.overflow) mismatch("overflow", exp_t.overflow, got.overflow);
         if (got.line !== exp_t.line)         mismatch("line", exp_t.line, got.line);
         if (got.column !== exp_t.column)     mismatch("column", exp_t.column, got.column);
         if (got.errors !== exp_t.errors)     mismatch("errors", exp_t.errors, got.errors);
         if (got.last !== exp_t.last)         mismatch("last", exp_t.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   stl_req_if req_chan ();
   stl_rsp_if rsp_chan ();

   source_token_lexer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lexer_token_checker scb = new();

   int  idle_pct  = 0;     // sender gap odds, percent
   int  stall_pct = 0;     // receiver stall odds, percent
   int  hold_left = 0;     // long receiver hold-off, in cycles
   bit  hold_req  = 0;
   int  cycle_count = 0;
   logic [8:0] byte_q[$];  // {end marker, byte} beats waiting to be sent

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      reset = 1;
      req_chan.valid = 0;
      req_chan.data_byte = 0;
      req_chan.end_of_input = 0;
      rsp_chan.ready = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
   end

   // Receiver: random stalls, plus a long hold-off counted here so the
   // lexer's token queue fills and it drops req ready.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 400;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 0;
      end else
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Response monitor; inputs only move at posedge, so negedge values hold
   // through the accepting edge.
   always @(negedge clock) begin
      stl_pkg::token_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind = rsp_chan.token_kind;
         got.value = rsp_chan.token_value;
         got.length = rsp_chan.token_length;
         got.overflow = rsp_chan.text_overflow;
         got.line = rsp_chan.start_line;
         got.column = rsp_chan.start_column;
         got.errors = rsp_chan.errors_so_far;
         got.last = rsp_chan.last_of_run;
         scb.check_token(got);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic eoi);
      bit took;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.data_byte <= b;
      req_chan.end_of_input <= eoi;
      took = 0;
      while (!took) begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end
      scb.note_beat(b, eoi);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back({1'b0, s[i]});
   endfunction

   function automatic void push_byte(logic [7:0] b);
      byte_q.push_back({1'b0, b});
   endfunction

   // end marker beats carry a random byte, which the lexer ignores
   function automatic void push_end();
      byte_q.push_back({1'b1, 8'($urandom_range(0, 255))});
   endfunction

   function automatic logic [7:0] pick_alpha();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      return "_";
   endfunction

   // One random lexical piece: mostly well-formed tokens, some noise.
   function automatic void push_piece();
      string ops[$] = '{",", ";", "=", "==", "!", "!=", "&", "|", "+", "-", "*", "/",
                        "%", "<", "<=", ">", ">=", "(", ")", "{", "}", "[", "]"};
      string hexd = "0123456789abcdefABCDEFgx";
      string escs = "abernt\\'x0q";
      int n;
      case ($urandom_range(0, 19))
         0, 1, 2: push_text(scb.kw_word($urandom_range(0, stl_pkg::KW_COUNT - 1)));
         3, 4: begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            push_byte(pick_alpha());
            for (int i = 1; i < n; i++)
               push_byte($urandom_range(0, 3) == 0 ? 8'(8'h30 + $urandom_range(0, 9))
                                                   : pick_alpha());
         end
         5, 6: begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) push_byte(8'(8'h30 + $urandom_range(0, 9)));
         end
         7, 8: begin
            push_byte("'");
            case ($urandom_range(0, 4))
               0: push_byte(8'($urandom_range(8'h20, 8'h7E)));
               1: begin push_byte("\\"); push_byte(escs[$urandom_range(0, escs.len()-1)]); end
               2: begin
                  push_text("\\x");
                  n = $urandom_range(0, 3);
                  for (int i = 0; i < n; i++) push_byte(hexd[$urandom_range(0, hexd.len()-1)]);
               end
               3: push_byte(8'($urandom_range(0, 31)));
               default: push_byte(8'($urandom_range(128, 255)));
            endcase
            if ($urandom_range(0, 3) != 0) push_byte("'");
         end
         9, 10, 11: push_text(ops[$urandom_range(0, ops.size()-1)]);
         12, 13, 14: push_byte($urandom_range(0, 3) == 0 ? 8'h0A
                                : (($urandom_range(0, 1) == 0) ? 8'h20
                                                               : 8'($urandom_range(9, 13))));
         15: begin
            push_byte("#");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
            push_byte(8'h0A);
         end
         16, 17: push_byte(8'($urandom_range(0, 255)));
         18: push_end();
         default: push_byte(" ");
      endcase
   endfunction

   initial begin
      int sent;
      @(negedge reset);
      @(posedge clock);

      // Directed: keyword and identifier, escapes, hex escape then quote,
      // comment, two-char operator, high byte, cut-off literal at the end.
      push_text("if x9 '\\x4f''\\e'#c\n<=!\\");
      push_byte(8'hFF);
      push_text("7'");
      push_end();
      while (byte_q.size() > 0) begin
         logic [8:0] e;
         e = byte_q.pop_front();
         send_beat(e[7:0], e[8]);
      end

      // phases: no idling, sender gaps, receiver stalls (with long hold), both
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 17 : 0;
         stall_pct = (ph == 2) ? 73 : (ph == 3) ? 17 : 0;
         if (ph == 2) hold_req = 1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            logic [8:0] e;
            if (byte_q.size() == 0) push_piece();
            e = byte_q.pop_front();
            send_beat(e[7:0], e[8]);
            sent++;
         end
      end
      // finish the last piece, then flush with an end marker
      push_end();
      while (byte_q.size() > 0) begin
         logic [8:0] e;
         e = byte_q.pop_front();
         send_beat(e[7:0], e[8]);
      end
      req_chan.valid <= 0;

      while (scb.expected_tokens.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scb.fails == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
